### sv/dda_line_rasterizer_defines.svh
// ----------------------------------------------------------------------------
// dda_line_rasterizer_defines.svh
// Assertion macros shared by the checker files of the line rasterizer.
// ----------------------------------------------------------------------------
`ifndef DDA_LINE_RASTERIZER_DEFINES_SVH
`define DDA_LINE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DDA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dda_line_rasterizer: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DDA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dda_line_rasterizer: next-cycle check failed");

`endif

### sv/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg
// Shared constants, opcodes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
`default_nettype none

package dda_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_start;  // latch endpoints, deltas and the first pixel
        logic div_iter;    // one quotient bit on both axes
        logic div_first;   // integer quotient bit: compare without shift
        logic div_fix;     // apply delta signs to the quotients
        logic advance;     // add increments, emit next pixel
    } dda_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic steps_zero;  // endpoints on the input beat coincide
        logic last_point;  // one pixel of the line remains
    } dda_stat_t;

endpackage

`default_nettype wire

### sv/dda_cmd_if.sv
// ----------------------------------------------------------------------------
// dda_cmd_if
// Input channel: start or advance beats with line endpoints.
// ----------------------------------------------------------------------------
`default_nettype none

interface dda_cmd_if
    import dda_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();

    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (
        output valid, op, start_x, start_y, end_x, end_y,
        input  ready
    );

    modport sink (
        input  valid, op, start_x, start_y, end_x, end_y,
        output ready
    );

endinterface

`default_nettype wire

### sv/dda_pixel_if.sv
// ----------------------------------------------------------------------------
// dda_pixel_if
// Output channel: one rasterized pixel per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface dda_pixel_if
    import dda_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last;

    modport source (
        output valid, pixel_x, pixel_y, last,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, last,
        output ready
    );

endinterface

`default_nettype wire

### sv/dda_ctrl.sv
// ----------------------------------------------------------------------------
// dda_ctrl
// Sequencer: handshakes, divider iteration count and line state.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_ctrl
    import dda_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_op,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    output dda_cmd_t       cmd,
    input  wire dda_stat_t stat
);

    localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_FIX  = 4'b0100,
        S_LINE = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic                accept;

    assign in_ready  = (state_reg != S_DIV) && (state_reg != S_FIX)
                    && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.load_start = accept && (in_op == OP_START);
        cmd.advance    = accept && (in_op == OP_ADVANCE) && (state_reg == S_LINE);
        cmd.div_iter   = (state_reg == S_DIV);
        cmd.div_first  = (state_reg == S_DIV) && (cnt_reg == '0);
        cmd.div_fix    = (state_reg == S_FIX);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg) inside
            S_IDLE, S_LINE:
            begin
                if (cmd.load_start)
                begin
                    cnt_next   = '0;
                    state_next = stat.steps_zero ? S_IDLE : S_DIV;
                end
                else if (cmd.advance && stat.last_point)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(FRAC_BITS))
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                state_next = S_LINE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output beat pending: set on every emitted pixel, drop once taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_start || cmd.advance)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### sv/dda_datapath.sv
// ----------------------------------------------------------------------------
// dda_datapath
// Deltas, restoring divider lanes for both axes, accumulators, pixel register.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_datapath
    import dda_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire dda_cmd_t              cmd,
    output dda_stat_t                  stat,
    input  wire logic [COORD_BITS-1:0] start_x,
    input  wire logic [COORD_BITS-1:0] start_y,
    input  wire logic [COORD_BITS-1:0] end_x,
    input  wire logic [COORD_BITS-1:0] end_y,
    output logic      [COORD_BITS-1:0] pixel_x,
    output logic      [COORD_BITS-1:0] pixel_y,
    output logic                       last
);

    localparam int ACC_BITS  = COORD_BITS + 1 + FRAC_BITS;
    localparam int STEP_BITS = FRAC_BITS + 2;
    localparam int REM_BITS  = COORD_BITS + 1;
    localparam int EXT_BITS  = ACC_BITS - STEP_BITS;
    localparam logic [FRAC_BITS-1:0] HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};

    // Accumulators carry a built-in +0.5 so that rounding is a bit select.
    logic [ACC_BITS-1:0]   x_acc_reg, y_acc_reg;
    logic [STEP_BITS-1:0]  x_step_reg, y_step_reg;
    logic [REM_BITS-1:0]   x_rem_reg, y_rem_reg;
    logic [FRAC_BITS:0]    x_quo_reg, y_quo_reg;
    logic                  x_neg_reg, y_neg_reg;
    logic [COORD_BITS-1:0] steps_reg, points_reg;
    logic [COORD_BITS-1:0] px_reg, py_reg;
    logic                  last_reg;

    logic                  x_neg, y_neg;
    logic [COORD_BITS-1:0] adx, ady, steps;
    logic [REM_BITS-1:0]   x_trial, y_trial, divisor;
    logic                  x_ge, y_ge;
    logic [STEP_BITS-1:0]  x_mag, y_mag;
    logic [ACC_BITS-1:0]   x_acc_sum, y_acc_sum;

    always_comb
    begin
        x_neg = end_x < start_x;
        y_neg = end_y < start_y;
        adx   = x_neg ? start_x - end_x : end_x - start_x;
        ady   = y_neg ? start_y - end_y : end_y - start_y;
        steps = (adx > ady) ? adx : ady;

        stat.steps_zero = (steps == '0);
        stat.last_point = (points_reg == COORD_BITS'(1));

        // The integer bit compares the raw remainder; fraction bits shift first.
        divisor = {1'b0, steps_reg};
        x_trial = cmd.div_first ? x_rem_reg : {x_rem_reg[REM_BITS-2:0], 1'b0};
        y_trial = cmd.div_first ? y_rem_reg : {y_rem_reg[REM_BITS-2:0], 1'b0};
        x_ge    = x_trial >= divisor;
        y_ge    = y_trial >= divisor;

        x_mag = {1'b0, x_quo_reg};
        y_mag = {1'b0, y_quo_reg};

        x_acc_sum = x_acc_reg + {{EXT_BITS{x_step_reg[STEP_BITS-1]}}, x_step_reg};
        y_acc_sum = y_acc_reg + {{EXT_BITS{y_step_reg[STEP_BITS-1]}}, y_step_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_start)
        begin
            x_acc_reg  <= {1'b0, start_x, HALF};
            y_acc_reg  <= {1'b0, start_y, HALF};
            x_rem_reg  <= {1'b0, adx};
            y_rem_reg  <= {1'b0, ady};
            x_neg_reg  <= x_neg;
            y_neg_reg  <= y_neg;
            steps_reg  <= steps;
            points_reg <= steps;
            px_reg     <= start_x;
            py_reg     <= start_y;
            last_reg   <= stat.steps_zero;
        end
        else if (cmd.div_iter)
        begin
            x_rem_reg <= x_ge ? x_trial - divisor : x_trial;
            y_rem_reg <= y_ge ? y_trial - divisor : y_trial;
            x_quo_reg <= {x_quo_reg[FRAC_BITS-1:0], x_ge};
            y_quo_reg <= {y_quo_reg[FRAC_BITS-1:0], y_ge};
        end
        else if (cmd.div_fix)
        begin
            x_step_reg <= x_neg_reg ? (~x_mag + STEP_BITS'(1)) : x_mag;
            y_step_reg <= y_neg_reg ? (~y_mag + STEP_BITS'(1)) : y_mag;
        end
        else if (cmd.advance)
        begin
            x_acc_reg  <= x_acc_sum;
            y_acc_reg  <= y_acc_sum;
            points_reg <= points_reg - COORD_BITS'(1);
            px_reg     <= x_acc_sum[FRAC_BITS +: COORD_BITS];
            py_reg     <= y_acc_sum[FRAC_BITS +: COORD_BITS];
            last_reg   <= stat.last_point;
        end
    end

    assign pixel_x = px_reg;
    assign pixel_y = py_reg;
    assign last    = last_reg;

endmodule

`default_nettype wire

### sv/dda_line_rasterizer.sv
// A pixel appears, registered, in the cycle after its start or advance beat is
// accepted. Advances go at one per cycle while the pixel output is not stalled;
// a start of nonzero length then holds cmd.ready low through S_DIV (one quotient
// bit per cycle) and S_FIX (signs applied).
// Reset (rst_n low, asynchronous): no line active, no pixel pending.
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer: start beats load endpoints, advance beats step pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_line_rasterizer
    import dda_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dda_cmd_if.sink    cmd,
    dda_pixel_if.source pixel
);

    dda_cmd_t  ctl_cmd;
    dda_stat_t ctl_stat;

    dda_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_op     (cmd.op),
        .in_ready  (cmd.ready),
        .out_valid (pixel.valid),
        .out_ready (pixel.ready),
        .cmd       (ctl_cmd),
        .stat      (ctl_stat)
    );

    dda_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk     (clk),
        .cmd     (ctl_cmd),
        .stat    (ctl_stat),
        .start_x (cmd.start_x),
        .start_y (cmd.start_y),
        .end_x   (cmd.end_x),
        .end_y   (cmd.end_y),
        .pixel_x (pixel.pixel_x),
        .pixel_y (pixel.pixel_y),
        .last    (pixel.last)
    );

endmodule

`default_nettype wire

### sv/dda_line_rasterizer_checker.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer_checker
// Port-level checks on the rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dda_line_rasterizer_defines.svh"

module dda_line_rasterizer_checker
    import dda_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic                  in_op,
    input wire logic [COORD_BITS-1:0] start_x,
    input wire logic [COORD_BITS-1:0] start_y,
    input wire logic [COORD_BITS-1:0] end_x,
    input wire logic [COORD_BITS-1:0] end_y,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [COORD_BITS-1:0] pixel_x,
    input wire logic [COORD_BITS-1:0] pixel_y,
    input wire logic                  last
);

    logic start_beat;
    logic point_line;

    assign start_beat = in_valid && in_ready && (in_op == OP_START);
    assign point_line = (start_x == end_x) && (start_y == end_y);

    // Hold a stalled pixel beat.
    `DDA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(last))

    // A zero-length line gives its single pixel as the end point.
    `DDA_ASSERT_NEXT(a_point_line, start_beat && point_line,
        out_valid && last && pixel_x == $past(start_x) && pixel_y == $past(start_y))

    // A real line opens with its start pixel, not flagged last.
    `DDA_ASSERT_NEXT(a_first_pixel, start_beat && !point_line,
        out_valid && !last && pixel_x == $past(start_x) && pixel_y == $past(start_y))

    // Increments are being computed right after a real start.
    `DDA_ASSERT_NEXT(a_div_busy, start_beat && !point_line, !in_ready)

endmodule

bind dda_line_rasterizer dda_line_rasterizer_checker #(
    .COORD_BITS (COORD_BITS)
) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .in_op     (cmd.op),
    .start_x   (cmd.start_x),
    .start_y   (cmd.start_y),
    .end_x     (cmd.end_x),
    .end_y     (cmd.end_y),
    .out_valid (pixel.valid),
    .out_ready (pixel.ready),
    .pixel_x   (pixel.pixel_x),
    .pixel_y   (pixel.pixel_y),
    .last      (pixel.last)
);

`default_nettype wire

### sim/dda_line_rasterizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dda_line_rasterizer_tb
// Self-checking bench for the DDA line rasterizer. Start and advance beats go
// through the command channel while a scoreboard tracks the accumulators and
// step increments in fixed point. It predicts every pixel, and each pixel
// beat is compared against the oldest prediction. A short directed set
// covers the edge cases. Random lines follow, most of them short and run to
// the end, with some cut off or overrun. The run passes through phases of
// sender gaps and receiver stalls, plus one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_line_rasterizer_tb;

    import dda_pkg::*;

    localparam int CB     = COORD_BITS_DEF;
    localparam int FB     = FRAC_BITS_DEF;
    localparam int ACC_W  = CB + 1 + FB;
    localparam int STEP_W = FB + 2;
    localparam int CNT_W  = CB + 1;
    localparam int COORD_MAX   = (1 << CB) - 1;
    localparam int BEAT_GOAL   = 1550;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 20000;

    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic          last;
    } pixel_t;

    class line_scoreboard;
        logic [ACC_W-1:0]  x_acc;
        logic [ACC_W-1:0]  y_acc;
        logic [STEP_W-1:0] x_inc;
        logic [STEP_W-1:0] y_inc;
        logic [CNT_W-1:0]  pts_left;
        bit                active;
        pixel_t            expected_pixels[$];
        int                errors;

        function new();
            x_acc    = '0;
            y_acc    = '0;
            x_inc    = '0;
            y_inc    = '0;
            pts_left = '0;
            active   = 1'b0;
            errors   = 0;
        endfunction

        // Signed Q2.F increment: magnitude truncated toward zero, then signed.
        function logic [STEP_W-1:0] increment(input logic neg, input logic [CB-1:0] mag,
                                              input logic [CB-1:0] steps);
            logic [CB+FB-1:0] quo;
            quo = {mag, {FB{1'b0}}} / steps;
            if (neg)
                quo = -quo;
            return quo[STEP_W-1:0];
        endfunction

        // Round half up to an integer coordinate.
        function logic [CB-1:0] to_coord(input logic [ACC_W-1:0] acc);
            logic [ACC_W-1:0] sum;
            sum = acc + (ACC_W'(1) << (FB - 1));
            return sum[FB +: CB];
        endfunction

        function void push_pixel(input logic last);
            pixel_t p;
            p.x    = to_coord(x_acc);
            p.y    = to_coord(y_acc);
            p.last = last;
            expected_pixels.push_back(p);
        endfunction

        function void note_beat(input logic op, input logic [CB-1:0] sx, sy, ex, ey);
            logic          xneg;
            logic          yneg;
            logic [CB-1:0] adx;
            logic [CB-1:0] ady;
            logic [CB-1:0] steps;
            if (op == OP_START) begin
                xneg  = ex < sx;
                yneg  = ey < sy;
                adx   = xneg ? sx - ex : ex - sx;
                ady   = yneg ? sy - ey : ey - sy;
                steps = (adx > ady) ? adx : ady;
                x_acc = {1'b0, sx, {FB{1'b0}}};
                y_acc = {1'b0, sy, {FB{1'b0}}};
                if (steps == '0) begin
                    x_inc    = '0;
                    y_inc    = '0;
                    pts_left = '0;
                    active   = 1'b0;
                    push_pixel(1'b1);
                end
                else begin
                    x_inc    = increment(xneg, adx, steps);
                    y_inc    = increment(yneg, ady, steps);
                    pts_left = {1'b0, steps};
                    active   = 1'b1;
                    push_pixel(1'b0);
                end
            end
            else if (active) begin
                x_acc    = x_acc + {{(ACC_W-STEP_W){x_inc[STEP_W-1]}}, x_inc};
                y_acc    = y_acc + {{(ACC_W-STEP_W){y_inc[STEP_W-1]}}, y_inc};
                pts_left = pts_left - 1'b1;
                if (pts_left == '0)
                    active = 1'b0;
                push_pixel(pts_left == '0);
            end
        endfunction

        task report(input string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_pixel(input logic [CB-1:0] x, y, input logic last);
            pixel_t p;
            if (expected_pixels.size() == 0) begin
                report($sformatf("unexpected pixel (%0d,%0d) last=%0b", x, y, last));
                return;
            end
            p = expected_pixels.pop_front();
            if (x !== p.x)
                report($sformatf("pixel_x got %0d want %0d", x, p.x));
            if (y !== p.y)
                report($sformatf("pixel_y got %0d want %0d", y, p.y));
            if (last !== p.last)
                report($sformatf("last got %0b want %0b at (%0d,%0d)", last, p.last, p.x, p.y));
        endtask

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    dda_cmd_if   #(.COORD_BITS(CB)) cmd ();
    dda_pixel_if #(.COORD_BITS(CB)) pixel ();

    dda_line_rasterizer #(
        .COORD_BITS (CB),
        .FRAC_BITS  (FB)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .pixel (pixel)
    );

    line_scoreboard sb = new();

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   beats_sent     = 0;
    logic recv_hold;
    logic hold_go        = 1'b0;

    always #2 clk = ~clk;

    // Pixel sink: check on each accepted beat, then pick the next ready.
    always @(posedge clk) begin
        if (!rst_n) begin
            pixel.ready <= 1'b0;
        end
        else begin
            if (pixel.valid === 1'b1 && pixel.ready === 1'b1)
                sb.check_pixel(pixel.pixel_x, pixel.pixel_y, pixel.last);
            if (recv_hold)
                pixel.ready <= 1'b0;
            else
                pixel.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input.
    initial begin : receiver_hold_off
        recv_hold = 1'b0;
        wait (hold_go === 1'b1);
        @(posedge clk);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold <= 1'b0;
    end

    initial begin : watchdog
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_beat(input logic op, input logic [CB-1:0] sx, sy, ex, ey);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid   <= 1'b1;
        cmd.op      <= op;
        cmd.start_x <= sx;
        cmd.start_y <= sy;
        cmd.end_x   <= ex;
        cmd.end_y   <= ey;
        do
            @(posedge clk);
        while (cmd.ready !== 1'b1);
        sb.note_beat(op, sx, sy, ex, ey);
        beats_sent++;
    endtask

    // Start a line, then issue n_adv advances carrying junk coordinates.
    task automatic draw_line(input int sx, sy, ex, ey, input int n_adv);
        send_beat(OP_START, CB'(sx), CB'(sy), CB'(ex), CB'(ey));
        repeat (n_adv)
            send_beat(OP_ADVANCE, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom));
    endtask

    function automatic int offset_coord(input int base, input int span);
        if (base < span || (base + span <= COORD_MAX && $urandom_range(1) == 1))
            return base + span;
        return base - span;
    endfunction

    task automatic run_random_lines(input int beat_goal);
        int sx;
        int sy;
        int ex;
        int ey;
        int adx;
        int ady;
        int steps;
        int n_adv;
        int kind;
        int mode;
        while (beats_sent < beat_goal) begin
            kind = $urandom_range(99);
            mode = $urandom_range(99);
            sx   = $urandom_range(COORD_MAX);
            sy   = $urandom_range(COORD_MAX);
            if (kind < 6) begin
                ex = $urandom_range(COORD_MAX);
                ey = $urandom_range(COORD_MAX);
            end
            else begin
                ex = offset_coord(sx, $urandom_range(40));
                ey = offset_coord(sy, $urandom_range(40));
            end
            adx   = (ex > sx) ? ex - sx : sx - ex;
            ady   = (ey > sy) ? ey - sy : sy - ey;
            steps = (adx > ady) ? adx : ady;
            // Long lines are mostly cut short to keep the run bounded.
            if (kind >= 2 && kind < 6)
                n_adv = $urandom_range((steps < 60) ? steps : 60);
            else if (mode < 75)
                n_adv = steps;
            else if (mode < 88)
                n_adv = steps + $urandom_range(3, 1);
            else
                n_adv = $urandom_range(steps);
            draw_line(sx, sy, ex, ey, n_adv);
        end
    endtask

    initial begin : stimulus
        int cycles;
        rst_n         = 1'b0;
        cmd.valid     = 1'b0;
        cmd.op        = OP_START;
        cmd.start_x   = '0;
        cmd.start_y   = '0;
        cmd.end_x     = '0;
        cmd.end_y     = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: stray advance, zero-length lines, corner to corner,
        // restart mid-line, overrun past the end, steep line with both deltas negative.
        send_beat(OP_ADVANCE, '1, '1, '1, '1);
        draw_line(0, 0, 0, 0, 0);
        draw_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0);
        draw_line(COORD_MAX, 0, 0, COORD_MAX, 3);
        draw_line(0, COORD_MAX, COORD_MAX, 0, 2);
        draw_line(5, 5, 8, 6, 4);
        draw_line(10, 20, 9, 15, 5);

        // Phase 0 has no idling; the long hold-off lands inside it.
        hold_go <= 1'b1;
        run_random_lines(BEAT_GOAL / 4);
        send_idle_pct = 70;
        run_random_lines(BEAT_GOAL / 2);
        send_idle_pct = 0;
        recv_stall_pct <= 70;
        run_random_lines(3 * BEAT_GOAL / 4);
        send_idle_pct = 32;
        recv_stall_pct <= 32;
        run_random_lines(BEAT_GOAL);
        cmd.valid <= 1'b0;

        cycles = 0;
        while (sb.pending() != 0 && cycles < DRAIN_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        if (sb.pending() != 0)
            sb.report($sformatf("%0d pixels never arrived", sb.pending()));
        repeat (8) @(posedge clk);

        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
